>>> rtl/msfi_pkg.sv
// Shared constants and types for the mass/surface fractal intensity pipeline.
// No dependencies; used by all rtl modules through scoped names.
`timescale 1ns / 1ps
package msfi_pkg;

    // 6.0 in Q3.16, one bit wider so dimension sums compare without overflow
    localparam logic [19:0] SIX_Q16 = 20'd393216;
    // ln(2) in Q.64
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    localparam int EXP_TERMS = 20;
    // registers per series term: products, middle sum, shift, reciprocal products, sum, shift
    localparam int TERM_LAT  = 6;
    // ln2 product, y, terms, final sum
    localparam int EXP_LAT   = 3 + EXP_TERMS * TERM_LAT;

    // log2 result, Q7.32 plus headroom
    typedef logic [39:0] lg_t;

endpackage

>>> rtl/msfi_log2.sv
// Pipelined log2 of a 128-bit nonzero integer, result in Q.32.
// Uses msfi_pkg; table of log2(1 + i/2^N) is built at elaboration.
`timescale 1ns / 1ps
module msfi_log2 #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic           clk,
    input  logic           en,
    input  logic [127:0]   value,
    output msfi_pkg::lg_t  result
);

    localparam int TB    = LOG_TABLE_BITS;
    localparam int DEPTH = 1 << TB;

    // each entry: {step to next entry [64:33], base [32:0]}
    typedef logic [64:0] rom_t [DEPTH];

    function automatic logic [32:0] tab_entry(input int i);
        logic [63:0]  y;
        logic [127:0] sq;
        logic [32:0]  r;
        y = 64'(DEPTH + i) << (62 - TB);
        r = '0;
        if (y[63])
        begin
            r = 33'h1_0000_0000;
        end
        else
        begin
            // repeated squaring in Q2.62
            for (int k = 31; k >= 0; k--)
            begin
                sq = y * y;
                y  = sq[125:62];
                if (y[63])
                begin
                    r[k] = 1'b1;
                    y    = y >> 1;
                end
            end
        end
        return r;
    endfunction

    function automatic rom_t rom_fill();
        rom_t        t;
        logic [32:0] a;
        logic [32:0] b;
        for (int i = 0; i < DEPTH; i++)
        begin
            a    = tab_entry(i);
            b    = tab_entry(i + 1);
            t[i] = {32'(b - a), a};
        end
        return t;
    endfunction

    localparam rom_t ROM = rom_fill();

    logic [127:0]  v1_reg;
    logic [6:0]    p_next;
    logic [6:0]    p1_reg;
    logic [127:0]  norm;
    logic [TB-1:0] idx_reg;
    logic [31:0]   rem2_reg;
    logic [6:0]    p2_reg;
    logic [64:0]   rom_reg;
    logic [31:0]   rem3_reg;
    logic [6:0]    p3_reg;
    logic [63:0]   prod_reg;
    logic [32:0]   base4_reg;
    logic [6:0]    p4_reg;
    msfi_pkg::lg_t res_reg;

    // leading one position
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (value[i])
                p_next = 7'(i);
        end
    end

    assign norm = v1_reg << (7'd127 - p1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg    <= value;
            p1_reg    <= p_next;
            idx_reg   <= norm[126 -: TB];
            rem2_reg  <= norm[126 - TB -: 32];
            p2_reg    <= p1_reg;
            rom_reg   <= ROM[idx_reg];
            rem3_reg  <= rem2_reg;
            p3_reg    <= p2_reg;
            prod_reg  <= 64'(rom_reg[64:33]) * 64'(rem3_reg);
            base4_reg <= rom_reg[32:0];
            p4_reg    <= p3_reg;
            res_reg   <= 40'({p4_reg, 32'b0}) + 40'(base4_reg) + 40'(prod_reg[63:32]);
        end
    end

    assign result = res_reg;

endmodule

>>> rtl/msfi_exp.sv
// Pipelined 2^(1-f) as a truncated exp series in Q.62, one term per six stages.
// Uses msfi_pkg for ln2 and the term count.
`timescale 1ns / 1ps
module msfi_exp (
    input  logic        clk,
    input  logic        en,
    input  logic [32:0] g,      // 1 - f in Q.32
    output logic [63:0] sum     // Q.62
);

    logic [64:0] pl_reg;
    logic [64:0] ph_reg;
    logic [96:0] yfull;
    logic [63:0] y0_reg;
    logic [63:0] sum_reg;

    logic [63:0] y_c [0:msfi_pkg::EXP_TERMS];
    logic [63:0] t_c [0:msfi_pkg::EXP_TERMS];
    logic [63:0] a_c [0:msfi_pkg::EXP_TERMS];

    assign yfull = {ph_reg, 32'b0} + 97'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg  <= 65'(g) * 65'(msfi_pkg::LN2_Q64[31:0]);
            ph_reg  <= 65'(g) * 65'(msfi_pkg::LN2_Q64[63:32]);
            y0_reg  <= 64'(yfull[96:34]);
            sum_reg <= a_c[msfi_pkg::EXP_TERMS] + t_c[msfi_pkg::EXP_TERMS];
        end
    end

    assign y_c[0] = y0_reg;
    assign t_c[0] = 64'h4000_0000_0000_0000;
    assign a_c[0] = '0;

    for (genvar k = 1; k <= msfi_pkg::EXP_TERMS; k++)
    begin : g_term
        localparam int           K   = k;
        localparam int           L   = $clog2(K);
        localparam logic [127:0] NUM = 128'(1) << (63 + L);
        // floor(v/k) == (v*M) >> (63+L) for all v < 2^63
        localparam logic [63:0]  M   = 64'(NUM / 128'(K) + 128'd1);

        logic [63:0]  ya_reg, yb_reg, yc_reg, yd_reg, ye_reg, yf_reg;
        logic [63:0]  aa_reg, ab_reg, ac_reg, ad_reg, ae_reg, af_reg;
        logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
        logic [63:0]  p00b_reg, p11b_reg;
        logic [64:0]  midb_reg;
        logic [127:0] full1;
        logic [63:0]  v_reg;
        logic [63:0]  m00_reg, m01_reg, m10_reg, m11_reg;
        logic [63:0]  m00b_reg, m11b_reg;
        logic [64:0]  mmid_reg;
        logic [127:0] full2;
        logic [63:0]  q_reg;

        assign full1 = {p11b_reg, p00b_reg} + (128'(midb_reg) << 32);
        assign full2 = {m11b_reg, m00b_reg} + (128'(mmid_reg) << 32);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // term * y
                ya_reg   <= y_c[k-1];
                aa_reg   <= a_c[k-1] + t_c[k-1];
                p00_reg  <= 64'(t_c[k-1][31:0])  * 64'(y_c[k-1][31:0]);
                p01_reg  <= 64'(t_c[k-1][31:0])  * 64'(y_c[k-1][63:32]);
                p10_reg  <= 64'(t_c[k-1][63:32]) * 64'(y_c[k-1][31:0]);
                p11_reg  <= 64'(t_c[k-1][63:32]) * 64'(y_c[k-1][63:32]);
                yb_reg   <= ya_reg;
                ab_reg   <= aa_reg;
                p00b_reg <= p00_reg;
                p11b_reg <= p11_reg;
                midb_reg <= 65'(p01_reg) + 65'(p10_reg);
                yc_reg   <= yb_reg;
                ac_reg   <= ab_reg;
                v_reg    <= full1[125:62];
                // divide by k through the reciprocal
                yd_reg   <= yc_reg;
                ad_reg   <= ac_reg;
                m00_reg  <= 64'(v_reg[31:0])  * 64'(M[31:0]);
                m01_reg  <= 64'(v_reg[31:0])  * 64'(M[63:32]);
                m10_reg  <= 64'(v_reg[63:32]) * 64'(M[31:0]);
                m11_reg  <= 64'(v_reg[63:32]) * 64'(M[63:32]);
                ye_reg   <= yd_reg;
                ae_reg   <= ad_reg;
                m00b_reg <= m00_reg;
                m11b_reg <= m11_reg;
                mmid_reg <= 65'(m01_reg) + 65'(m10_reg);
                yf_reg   <= ye_reg;
                af_reg   <= ae_reg;
                q_reg    <= 64'(full2 >> (63 + L));
            end
        end

        assign y_c[k] = yf_reg;
        assign t_c[k] = q_reg;
        assign a_c[k] = af_reg;
    end

    assign sum = sum_reg;

endmodule

>>> rtl/mass_surface_fractal_intensity.sv
// Top level: mass fractal of surface fractal primaries, one q point per word.
// Depends on msfi_pkg, msfi_log2 and msfi_exp.
`timescale 1ns / 1ps
// The block takes one (q_x, q_y) word per clock and returns one intensity word per
// clock while the skid entry is empty; the depth is set mostly by the exp series,
// twenty terms of six stages each, with the log2 table lookups and the wide products
// making up the rest. A two-entry output buffer lets input continue while a finished
// word waits. Configuration is held in registers and may be written between runs.
module mass_surface_fractal_intensity #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // q_x [31:0], q_y [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // intensity [63:0]
    output logic        m_axis_tuser    // model_valid [0]
);

    localparam logic [2:0] CFG_SCALE = 3'd0;
    localparam logic [2:0] CFG_MASS  = 3'd1;
    localparam logic [2:0] CFG_SURF  = 3'd2;
    localparam logic [2:0] CFG_RC    = 3'd3;
    localparam logic [2:0] CFG_RP    = 3'd4;
    localparam logic [2:0] CFG_BG    = 3'd5;

    localparam int PIPE_LAT = 16 + msfi_pkg::EXP_LAT + 3;

    typedef struct packed {
        logic        model_valid;
        logic [63:0] intensity;
    } out_word_t;

    // configuration
    logic [31:0] scale_reg;
    logic [18:0] dm_reg;
    logic [18:0] ds_reg;
    logic [23:0] rc_reg;
    logic [23:0] rp_reg;
    logic [31:0] bg_reg;

    // derived from configuration, free running
    logic [19:0] dsum;
    logic        cfg_ok_reg;
    logic [18:0] t2_reg;
    logic        t2nz_reg;
    logic [20:0] d3_reg [2];
    logic [47:0] r2_reg [2];
    logic [63:0] bgq;

    logic                adv;
    logic [PIPE_LAT-1:0] vld_reg;

    logic [31:0]  qx, qy;
    logic [31:0]  ax_reg, ay_reg;
    logic [63:0]  sqx_reg, sqy_reg;
    logic [63:0]  q2_reg;
    logic [63:0]  ll_reg  [2];
    logic [47:0]  lh_reg  [2];
    logic [63:0]  hl_reg  [2];
    logic [47:0]  hh_reg  [2];
    logic [63:0]  ll5_reg [2];
    logic [47:0]  hh5_reg [2];
    logic [64:0]  mid_reg [2];
    logic [111:0] prod_reg [2];
    logic [127:0] x_reg   [2];
    msfi_pkg::lg_t big_lg   [2];
    msfi_pkg::lg_t small_lg [2];
    msfi_pkg::lg_t adj      [2];
    msfi_pkg::lg_t lg_reg   [2];
    logic [58:0]  pa_reg, pb_reg;
    logic [59:0]  acc_reg;
    logic [32:0]  g_reg;
    logic [10:0]  n_reg;
    logic [10:0]  n_dly_reg [msfi_pkg::EXP_LAT];
    logic [63:0]  exp_sum;
    logic [63:0]  ps_lo_reg, ps_hi_reg;
    logic [10:0]  nf1_reg;
    logic [95:0]  p96_reg;
    logic         far_reg;
    logic [5:0]   nf2_reg;
    logic [63:0]  mag_reg;

    logic      push, pop;
    out_word_t res;
    logic      out_valid_reg, skid_valid_reg;
    out_word_t out_reg, skid_reg;

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 32'd65536;
            dm_reg    <= 19'd117965;
            ds_reg    <= 19'd150733;
            rc_reg    <= 24'd22195;
            rp_reg    <= 24'd1024000;
            bg_reg    <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_wdata;
                CFG_MASS:  dm_reg    <= cfg_wdata[18:0];
                CFG_SURF:  ds_reg    <= cfg_wdata[18:0];
                CFG_RC:    rc_reg    <= cfg_wdata[23:0];
                CFG_RP:    rp_reg    <= cfg_wdata[23:0];
                CFG_BG:    bg_reg    <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign dsum = 20'(dm_reg) + 20'(ds_reg);
    assign bgq  = {{16{bg_reg[31]}}, bg_reg, 16'b0};

    always_ff @(posedge clk)
    begin
        cfg_ok_reg <= (dm_reg != '0) && (ds_reg != '0) && (20'(dm_reg) <= msfi_pkg::SIX_Q16)
                      && (20'(ds_reg) <= msfi_pkg::SIX_Q16) && (dsum <= msfi_pkg::SIX_Q16);
        t2_reg     <= 19'(msfi_pkg::SIX_Q16 - dsum);
        t2nz_reg   <= t2_reg != '0;
        d3_reg[0]  <= 21'(dm_reg) * 21'd3;
        d3_reg[1]  <= 21'(t2_reg) * 21'd3;
        r2_reg[0]  <= 48'(rc_reg) * 48'(rc_reg);
        r2_reg[1]  <= 48'(rp_reg) * 48'(rp_reg);
    end

    // ---------------- pipeline control ----------------
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
    end

    // ---------------- q^2 and q^2*R^2 ----------------
    assign qx = s_axis_tdata[31:0];
    assign qy = s_axis_tdata[63:32];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= qx[31] ? (~qx + 32'd1) : qx;
            ay_reg  <= qy[31] ? (~qy + 32'd1) : qy;
            sqx_reg <= 64'(ax_reg) * 64'(ax_reg);
            sqy_reg <= 64'(ay_reg) * 64'(ay_reg);
            q2_reg  <= sqx_reg + sqy_reg;
        end
    end

    for (genvar f = 0; f < 2; f++)
    begin : g_factor
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ll_reg[f]   <= 64'(q2_reg[31:0])  * 64'(r2_reg[f][31:0]);
                lh_reg[f]   <= 48'(q2_reg[31:0])  * 48'(r2_reg[f][47:32]);
                hl_reg[f]   <= 64'(q2_reg[63:32]) * 64'(r2_reg[f][31:0]);
                hh_reg[f]   <= 48'(q2_reg[63:32]) * 48'(r2_reg[f][47:32]);
                ll5_reg[f]  <= ll_reg[f];
                hh5_reg[f]  <= hh_reg[f];
                mid_reg[f]  <= 65'(lh_reg[f]) + 65'(hl_reg[f]);
                prod_reg[f] <= {hh5_reg[f], ll5_reg[f]} + (112'(mid_reg[f]) << 32);
                // 3*den*2^56 + 2*q2*R2
                x_reg[f]    <= 128'({prod_reg[f], 1'b0}) + (128'(d3_reg[f]) << 56);
            end
        end

        msfi_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log_big (
            .clk    (clk),
            .en     (adv),
            .value  (x_reg[f]),
            .result (big_lg[f])
        );

        msfi_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log_small (
            .clk    (clk),
            .en     (adv),
            .value  (128'(d3_reg[f])),
            .result (small_lg[f])
        );

        assign adj[f] = small_lg[f] + 40'h38_0000_0000;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (big_lg[f] > adj[f] && (f == 0 || t2nz_reg))
                    lg_reg[f] <= big_lg[f] - adj[f];
                else
                    lg_reg[f] <= '0;
            end
        end
    end

    // ---------------- L = (dm*lg1 + t2*lg2) >> 17 ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg  <= 59'(dm_reg) * 59'(lg_reg[0]);
            pb_reg  <= 59'(t2_reg) * 59'(lg_reg[1]);
            acc_reg <= 60'(pa_reg) + 60'(pb_reg);
            g_reg   <= 33'h1_0000_0000 - 33'(acc_reg[48:17]);
            n_reg   <= acc_reg[59:49];
            n_dly_reg[0] <= n_reg;
            for (int i = 1; i < msfi_pkg::EXP_LAT; i++)
                n_dly_reg[i] <= n_dly_reg[i-1];
        end
    end

    msfi_exp u_exp (
        .clk (clk),
        .en  (adv),
        .g   (g_reg),
        .sum (exp_sum)
    );

    // ---------------- scale * 2^(1-f) >> (47 + n) ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_lo_reg <= 64'(scale_reg) * 64'(exp_sum[31:0]);
            ps_hi_reg <= 64'(scale_reg) * 64'(exp_sum[63:32]);
            nf1_reg   <= n_dly_reg[msfi_pkg::EXP_LAT-1];
            p96_reg   <= 96'(ps_lo_reg) + (96'(ps_hi_reg) << 32);
            far_reg   <= nf1_reg > 11'd48;
            nf2_reg   <= nf1_reg[5:0];
            mag_reg   <= far_reg ? 64'd0 : 64'(p96_reg >> (7'd47 + 7'(nf2_reg)));
        end
    end

    assign res.model_valid = cfg_ok_reg;
    assign res.intensity   = cfg_ok_reg ? (mag_reg + bgq) : bgq;

    // ---------------- output register and skid ----------------
    assign push = adv && vld_reg[PIPE_LAT-1];
    assign pop  = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res;
        end
        else if (push)
            skid_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.intensity;
    assign m_axis_tuser  = out_reg.model_valid;

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_no_push_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("pipeline advanced into a full skid stage");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("stalled result word was dropped");

endmodule
